/* sv/assert_macros.svh */
// Assertion macros used by the top level of the span builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("expected follow-up condition missing");
`else
`define AST_NEVER(lbl, clk, rst, expr)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/cpsb_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package cpsb_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int MAX_ROWS     = 1024;
  localparam int COORD_BITS   = 16;

  localparam int VADDR_W    = $clog2(MAX_VERTICES);
  localparam int VCNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int SPAN_DEPTH = MAX_ROWS + 1;
  localparam int SPAN_W     = 11;
  localparam int EXT_AW     = $clog2(SPAN_DEPTH);
  localparam int WALK_W     = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 4;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 11;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIDTH_W-1:0]  SCREEN_WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_ADD_VERTEX = 1'b0,
    CMD_READ_SPAN  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic store_vertex;
    logic issue_read;
    logic res_vertex;
    logic res_read;
    logic bounds;
    logic clear_step;
    logic vtx_rd0;
    logic vtx_cap0;
    logic edge_cap;
    logic use_first;
    logic setup;
    logic mark_rd;
    logic mark_wr;
    logic mark_skip;
    logic edge_next;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic edge_done;
    logic in_range;
    logic last_edge;
    logic clear_done;
  } dp_stat_t;
endpackage

/* sv/cpsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cpsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/cpsb_dp.sv */
// Datapath: vertex and extent memories, bounds, edge walker and result registers.
module cpsb_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cpsb_pkg::dp_cmd_t                      cmd,
  output cpsb_pkg::dp_stat_t                     stat,
  input  logic                                   cfg_valid,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cpsb_pkg::WIDTH_W-1:0]           cfg_data,
  input  logic signed [cpsb_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [cpsb_pkg::COORD_BITS-1:0] vertex_y,
  input  logic [cpsb_pkg::SPAN_W-1:0]            span_index,
  output logic                                   spans_ready,
  output logic [cpsb_pkg::SPAN_W-1:0]            span_total,
  output logic [cpsb_pkg::SPAN_W-1:0]            top_row,
  output logic [cpsb_pkg::ROW_W-1:0]             span_row,
  output logic signed [cpsb_pkg::COORD_BITS-1:0] span_left,
  output logic signed [cpsb_pkg::COORD_BITS-1:0] span_right,
  output logic                                   span_empty,
  output logic                                   vertex_overflow
);
  localparam int CB = cpsb_pkg::COORD_BITS;
  localparam int WW = cpsb_pkg::WALK_W;
  localparam int EW = cpsb_pkg::ERR_W;
  localparam int SW = cpsb_pkg::SPAN_W;
  localparam int DW = WW + 1;
  localparam int RW = cpsb_pkg::ROW_W;

  logic [cpsb_pkg::WIDTH_W-1:0]  screen_width;
  logic [cpsb_pkg::HEIGHT_W-1:0] screen_height;
  logic [cpsb_pkg::VCNT_W-1:0]   vertex_count;
  logic [cpsb_pkg::VCNT_W-1:0]   k;
  logic [cpsb_pkg::VCNT_W-1:0]   k_plus1;
  logic                          ready_flag;
  logic                          overflow_flag;
  logic                          overflow_next;
  logic                          room;
  logic signed [CB-1:0]          vmin;
  logic signed [CB-1:0]          vmax;
  logic [SW-1:0]                 first_row;
  logic [SW-1:0]                 span_count;
  logic [SW-1:0]                 yres;
  logic [SW-1:0]                 clr_cnt;
  logic [SW-1:0]                 idx_reg;
  logic [cpsb_pkg::EXT_AW-1:0]   mark_idx;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= cpsb_pkg::SCREEN_WIDTH_RESET;
      screen_height <= cpsb_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cpsb_pkg::cfg_reg_t'(cfg_index))
        cpsb_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        cpsb_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[cpsb_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Vertex memory.
  logic [2*CB-1:0]              vrd;
  logic [cpsb_pkg::VADDR_W-1:0] vraddr;

  assign room          = vertex_count < cpsb_pkg::VCNT_W'(cpsb_pkg::MAX_VERTICES);
  assign k_plus1       = k + 1'b1;
  assign vraddr        = cmd.vtx_rd0 ? '0 : k_plus1[cpsb_pkg::VADDR_W-1:0];
  assign overflow_next = room ? ((vertex_count == '0) ? 1'b0 : overflow_flag) : 1'b1;

  cpsb_ram #(.WIDTH(2*CB), .DEPTH(cpsb_pkg::MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (cmd.store_vertex && room),
    .waddr (vertex_count[cpsb_pkg::VADDR_W-1:0]),
    .wdata ({vertex_x, vertex_y}),
    .raddr (vraddr),
    .rdata (vrd)
  );

  // Edge walker registers.
  logic signed [CB-1:0] first_x, first_y, cur_x, cur_y, nxt_x, nxt_y;
  logic signed [WW-1:0] wc, wf, wr;
  logic signed [EW-1:0] g, inc1, inc2;
  logic                 steep, rising;

  // Setup arithmetic for the current edge.
  logic signed [WW-1:0] dx, dy, adx, ady;
  logic signed [EW-1:0] adx_e, ady_e;
  logic                 dx_pos, dy_pos, steep_c;

  always_comb begin
    dx      = WW'(nxt_x) - WW'(cur_x);
    dy      = WW'(nxt_y) - WW'(cur_y);
    adx     = dx[WW-1] ? -dx : dx;
    ady     = dy[WW-1] ? -dy : dy;
    adx_e   = EW'(adx);
    ady_e   = EW'(ady);
    dx_pos  = !dx[WW-1] && (dx != '0);
    dy_pos  = !dy[WW-1] && (dy != '0);
    steep_c = !(adx > ady);
  end

  // Current pixel: row and column depend on which axis is stepped.
  logic signed [WW-1:0] row_w, x_w;
  logic signed [DW-1:0] diff;
  logic                 step_up;
  logic signed [CB-1:0] lrd, rrd;

  assign row_w   = steep ? wc : wr;
  assign x_w     = steep ? wr : wc;
  assign diff    = DW'(row_w) - $signed(DW'(first_row));
  assign step_up = rising ? !g[EW-1] : (!g[EW-1] && (g != '0));

  assign stat.edge_done  = wc > wf;
  assign stat.in_range   = !row_w[WW-1] && (row_w < $signed(WW'(yres))) &&
                           !diff[DW-1] && (diff < $signed(DW'(span_count)));
  assign stat.last_edge  = k_plus1 == vertex_count;
  assign stat.clear_done = clr_cnt == span_count - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.vtx_cap0) begin
      first_x <= vrd[2*CB-1:CB];
      first_y <= vrd[CB-1:0];
      cur_x   <= vrd[2*CB-1:CB];
      cur_y   <= vrd[CB-1:0];
    end else if (cmd.edge_next) begin
      cur_x <= nxt_x;
      cur_y <= nxt_y;
    end
    if (cmd.edge_cap) begin
      nxt_x <= vrd[2*CB-1:CB];
      nxt_y <= vrd[CB-1:0];
    end else if (cmd.use_first) begin
      nxt_x <= first_x;
      nxt_y <= first_y;
    end
    if (cmd.setup) begin
      steep  <= steep_c;
      rising <= dx_pos != dy[WW-1];
      if (!steep_c) begin
        wc   <= dx_pos ? WW'(cur_x) : WW'(nxt_x);
        wr   <= dx_pos ? WW'(cur_y) : WW'(nxt_y);
        wf   <= dx_pos ? WW'(nxt_x) : WW'(cur_x);
        inc1 <= ady_e <<< 1;
        g    <= (ady_e <<< 1) - adx_e;
        inc2 <= (ady_e - adx_e) <<< 1;
      end else begin
        wc   <= dy_pos ? WW'(cur_y) : WW'(nxt_y);
        wr   <= dy_pos ? WW'(cur_x) : WW'(nxt_x);
        wf   <= dy_pos ? WW'(nxt_y) : WW'(cur_y);
        inc1 <= adx_e <<< 1;
        g    <= (adx_e <<< 1) - ady_e;
        inc2 <= (adx_e - ady_e) <<< 1;
      end
    end else if (cmd.mark_wr || cmd.mark_skip) begin
      wc <= wc + 1'b1;
      if (step_up) begin
        wr <= rising ? wr + 1'b1 : wr - 1'b1;
        g  <= g + inc2;
      end else begin
        g <= g + inc1;
      end
    end
    if (cmd.mark_rd) begin
      mark_idx <= diff[cpsb_pkg::EXT_AW-1:0];
    end
    if (cmd.issue_read) begin
      idx_reg <= span_index;
    end
  end

  // Extent memories.
  logic                        ext_we;
  logic [cpsb_pkg::EXT_AW-1:0] ext_waddr, ext_raddr;
  logic signed [CB-1:0]        lwd, rwd, x16;

  assign x16       = x_w[CB-1:0];
  assign ext_we    = cmd.clear_step || cmd.mark_wr;
  assign ext_waddr = cmd.clear_step ? clr_cnt : mark_idx;
  assign ext_raddr = cmd.issue_read ? ((span_index < span_count) ? span_index : '0)
                                    : diff[cpsb_pkg::EXT_AW-1:0];
  assign lwd = cmd.clear_step ? (CB'(screen_width) + CB'(1)) : ((x16 < lrd) ? x16 : lrd);
  assign rwd = cmd.clear_step ? '1 : ((x16 > rrd) ? x16 : rrd);

  cpsb_ram #(.WIDTH(CB), .DEPTH(cpsb_pkg::SPAN_DEPTH)) u_left (
    .clk (clk), .we (ext_we), .waddr (ext_waddr), .wdata (lwd),
    .raddr (ext_raddr), .rdata (lrd)
  );

  cpsb_ram #(.WIDTH(CB), .DEPTH(cpsb_pkg::SPAN_DEPTH)) u_right (
    .clk (clk), .we (ext_we), .waddr (ext_waddr), .wdata (rwd),
    .raddr (ext_raddr), .rdata (rrd)
  );

  // Row bounds of the closed polygon, clamped to the screen.
  logic [SW-1:0]        yres_c;
  logic signed [WW-1:0] yres_e, lo_a, lo_b, hi_a, hi_b, n_a;

  always_comb begin
    yres_c = (screen_height > SW'(cpsb_pkg::MAX_ROWS)) ? SW'(cpsb_pkg::MAX_ROWS)
                                                       : screen_height;
    yres_e = $signed(WW'(yres_c));
    lo_a   = (WW'(vmin) < yres_e) ? WW'(vmin) : yres_e;
    lo_b   = lo_a[WW-1] ? '0 : lo_a;
    hi_a   = (WW'(vmax) > $signed(WW'(0))) ? WW'(vmax) : '0;
    hi_b   = (hi_a > yres_e) ? yres_e : hi_a;
    n_a    = hi_b - lo_b + 1'b1;
  end

  // Control state of the polygon and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      ready_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      first_row     <= '0;
      span_count    <= '0;
      k             <= '0;
      clr_cnt       <= '0;
    end else begin
      if (cmd.store_vertex) begin
        ready_flag    <= 1'b0;
        overflow_flag <= overflow_next;
        if (room) begin
          vertex_count <= vertex_count + 1'b1;
          if (vertex_count == '0) begin
            vmin <= vertex_y;
            vmax <= vertex_y;
          end else begin
            if (vertex_y < vmin) vmin <= vertex_y;
            if (vertex_y > vmax) vmax <= vertex_y;
          end
        end
      end
      if (cmd.bounds) begin
        yres       <= yres_c;
        first_row  <= lo_b[SW-1:0];
        span_count <= (n_a < $signed(WW'(1))) ? SW'(1) : n_a[SW-1:0];
        clr_cnt    <= '0;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.vtx_cap0) begin
        k <= '0;
      end else if (cmd.edge_next) begin
        k <= k_plus1;
      end
      if (cmd.finish) begin
        ready_flag   <= 1'b1;
        vertex_count <= '0;
      end
    end
  end

  // Result registers.
  logic hit;
  assign hit = ready_flag && (idx_reg < span_count) && (rrd >= lrd);

  always_ff @(posedge clk) begin
    if (cmd.res_vertex || cmd.finish) begin
      spans_ready     <= cmd.finish;
      span_total      <= span_count;
      top_row         <= first_row;
      span_row        <= '0;
      span_left       <= '0;
      span_right      <= '0;
      span_empty      <= 1'b0;
      vertex_overflow <= cmd.finish ? overflow_flag : overflow_next;
    end else if (cmd.res_read) begin
      spans_ready     <= ready_flag;
      span_total      <= span_count;
      top_row         <= first_row;
      span_row        <= RW'(first_row) + RW'(idx_reg);
      span_left       <= hit ? lrd : '0;
      span_right      <= hit ? rrd : '1;
      span_empty      <= !hit;
      vertex_overflow <= overflow_flag;
    end
  end
endmodule

/* sv/cpsb_ctrl.sv */
// Controller state machine sequencing loads, reads and span construction.
module cpsb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  cpsb_pkg::cmd_t     item_cmd,
  input  logic               item_closes,
  output logic               result_valid,
  input  logic               result_ready,
  output cpsb_pkg::dp_cmd_t  dcmd,
  input  cpsb_pkg::dp_stat_t stat
);
  typedef enum logic [11:0] {
    S_IDLE    = 12'h001,
    S_RD_WAIT = 12'h002,
    S_BOUNDS  = 12'h004,
    S_CLEAR   = 12'h008,
    S_V0_RD   = 12'h010,
    S_V0_WT   = 12'h020,
    S_EDGE_RD = 12'h040,
    S_EDGE_WT = 12'h080,
    S_SETUP   = 12'h100,
    S_MARK    = 12'h200,
    S_MARK_WR = 12'h400,
    S_FINISH  = 12'h800
  } state_t;

  state_t state, state_next;
  logic   rv_set;
  logic   accept;

  assign item_ready = (state == S_IDLE) && !result_valid;
  assign accept     = item_valid && item_ready;

  always_comb begin
    state_next = state;
    dcmd       = '0;
    rv_set     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (item_cmd == cpsb_pkg::CMD_READ_SPAN) begin
            dcmd.issue_read = 1'b1;
            state_next      = S_RD_WAIT;
          end else begin
            dcmd.store_vertex = 1'b1;
            if (item_closes) begin
              state_next = S_BOUNDS;
            end else begin
              dcmd.res_vertex = 1'b1;
              rv_set          = 1'b1;
            end
          end
        end
      end
      S_RD_WAIT: begin
        dcmd.res_read = 1'b1;
        rv_set        = 1'b1;
        state_next    = S_IDLE;
      end
      S_BOUNDS: begin
        dcmd.bounds = 1'b1;
        state_next  = S_CLEAR;
      end
      S_CLEAR: begin
        dcmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_V0_RD;
      end
      S_V0_RD: begin
        dcmd.vtx_rd0 = 1'b1;
        state_next   = S_V0_WT;
      end
      S_V0_WT: begin
        dcmd.vtx_cap0 = 1'b1;
        state_next    = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        if (stat.last_edge) begin
          dcmd.use_first = 1'b1;
          state_next     = S_SETUP;
        end else begin
          state_next = S_EDGE_WT;
        end
      end
      S_EDGE_WT: begin
        dcmd.edge_cap = 1'b1;
        state_next    = S_SETUP;
      end
      S_SETUP: begin
        dcmd.setup = 1'b1;
        state_next = S_MARK;
      end
      S_MARK: begin
        if (stat.edge_done) begin
          dcmd.edge_next = 1'b1;
          state_next     = stat.last_edge ? S_FINISH : S_EDGE_RD;
        end else if (stat.in_range) begin
          dcmd.mark_rd = 1'b1;
          state_next   = S_MARK_WR;
        end else begin
          dcmd.mark_skip = 1'b1;
        end
      end
      S_MARK_WR: begin
        dcmd.mark_wr = 1'b1;
        state_next   = S_MARK;
      end
      S_FINISH: begin
        dcmd.finish = 1'b1;
        rv_set      = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rv_set) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end
endmodule

/* sv/convex_polygon_span_builder_unit.sv */
// Top level: convex polygon span builder (controller plus datapath).
// A vertex load answers in the cycle after its request; a span read waits in S_RD_WAIT first.
// A closing vertex runs the bounds step, clears span_total extent rows, then for each edge
// reads the next vertex, sets up and walks its pixels, writing on-screen ones and skipping the rest.
// One request is in flight at a time; a new request is taken once the result is taken.
// Synchronous reset clears control state, configuration and counters; memories, edge walker and result registers hold.
`include "assert_macros.svh"
module convex_polygon_span_builder_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  logic                                   cmd,
  input  logic signed [cpsb_pkg::COORD_BITS-1:0] vertex_x,
  input  logic signed [cpsb_pkg::COORD_BITS-1:0] vertex_y,
  input  logic                                   closes_polygon,
  input  logic [cpsb_pkg::SPAN_W-1:0]            span_index,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic                                   spans_ready,
  output logic [cpsb_pkg::SPAN_W-1:0]            span_total,
  output logic [cpsb_pkg::SPAN_W-1:0]            top_row,
  output logic [cpsb_pkg::ROW_W-1:0]             span_row,
  output logic signed [cpsb_pkg::COORD_BITS-1:0] span_left,
  output logic signed [cpsb_pkg::COORD_BITS-1:0] span_right,
  output logic                                   span_empty,
  output logic                                   vertex_overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cpsb_pkg::WIDTH_W-1:0]           cfg_data
);
  cpsb_pkg::dp_cmd_t  dcmd;
  cpsb_pkg::dp_stat_t stat;

  // Configuration writes are registered directly, so the port is always ready.
  assign cfg_ready = 1'b1;

  // The controller walks each request through its states and drives the datapath.
  cpsb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_cmd     (cpsb_pkg::cmd_t'(cmd)),
    .item_closes  (closes_polygon),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .dcmd         (dcmd),
    .stat         (stat)
  );

  // The datapath holds the memories, the edge walker and the result registers.
  cpsb_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dcmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .vertex_x        (vertex_x),
    .vertex_y        (vertex_y),
    .span_index      (span_index),
    .spans_ready     (spans_ready),
    .span_total      (span_total),
    .top_row         (top_row),
    .span_row        (span_row),
    .span_left       (span_left),
    .span_right      (span_right),
    .span_empty      (span_empty),
    .vertex_overflow (vertex_overflow)
  );

  // A new request is never taken while a result is still waiting.
  `AST_NEVER(a_no_overlap, clk, rst, item_ready && result_valid)
  // A vertex that does not close the polygon answers in the next cycle.
  `AST_NEXT(a_vertex_fast, clk, rst, item_valid && item_ready && !cmd && !closes_polygon, result_valid)
  // After a request is taken the block stops taking more until it is answered.
  `AST_NEXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready)
endmodule
